>>> hdl/lcwe_pkg.sv
package lcwe_pkg;

    // Field and register widths.
    localparam int TIME_W = 32;
    localparam int AMP_W  = 18;
    localparam int RATE_W = 27;
    localparam int CUR_W  = 26;
    localparam int IDX_W  = 2;

    // Q1.31 fixed point, 1.0 = 2^31.
    localparam logic [31:0] FX_ONE = 32'h8000_0000;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_PEAK  = 2'd0;
    localparam logic [IDX_W-1:0] REG_DECAY = 2'd1;
    localparam logic [IDX_W-1:0] REG_RISE  = 2'd2;
    localparam logic [IDX_W-1:0] REG_FRONT = 2'd3;

    // Reset values (preset A).
    localparam logic [AMP_W-1:0]  PEAK_RST  = 18'd218810;
    localparam logic [RATE_W-1:0] DECAY_RST = 27'd48765;
    localparam logic [RATE_W-1:0] RISE_RST  = 27'd2779982;
    localparam logic [RATE_W-1:0] FRONT_RST = 27'd23293927;

    // Pipeline depths.
    localparam int EXP_LAT = 26;
    localparam int MIX_LAT = 4;
    localparam int LAT     = EXP_LAT + MIX_LAT;

endpackage

>>> hdl/lcwe_exp.sv
module lcwe_exp (
    input  logic                         clk,
    input  logic                         en,
    input  logic [lcwe_pkg::RATE_W-1:0]  rate,
    input  logic [lcwe_pkg::TIME_W-1:0]  time_ns,
    output logic [31:0]                  value
);
    import lcwe_pkg::*;

    // Arguments at or above 24.0 in Q.32 give zero.
    localparam logic [58:0] ARG_LIMIT = 59'd24 << 32;

    logic [58:0] x_reg;
    logic [30:0] y0_reg;
    logic        z0_reg;

    logic [31:0] hp [11];
    logic [30:0] hy [11];
    logic        hz [11];

    logic [31:0] sp [6];
    logic        sz [6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= 59'(rate) * 59'(time_ns);
            z0_reg <= (x_reg >= ARG_LIMIT);
            y0_reg <= x_reg[36:6];
        end
    end

    assign hp[0] = FX_ONE;
    assign hy[0] = y0_reg;
    assign hz[0] = z0_reg;

    // Horner evaluation of the Taylor series, one term per step.
    for (genvar j = 0; j < 10; j++)
    begin : g_horner
        localparam int K = 10 - j;
        logic [62:0] prod;
        logic [30:0] qa_reg;
        logic [30:0] ya_reg;
        logic        za_reg;

        assign prod = 63'(hy[j]) * 63'(hp[j]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qa_reg <= prod[61:31];
                ya_reg <= hy[j];
                za_reg <= hz[j];
            end
        end

        if (K > 1)
        begin : g_div
            // Exact quotient for 31-bit dividends: q/K = (q*M) >> 35.
            localparam logic [34:0] M = 35'((64'd1 << 35) / K + 1);
            logic [65:0] prod2;
            logic [30:0] qb_reg;
            logic [30:0] yb_reg;
            logic        zb_reg;

            assign prod2 = 66'(qa_reg) * 66'(M);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    qb_reg <= prod2[65:35];
                    yb_reg <= ya_reg;
                    zb_reg <= za_reg;
                end
            end

            assign hp[j+1] = FX_ONE - {1'b0, qb_reg};
            assign hy[j+1] = yb_reg;
            assign hz[j+1] = zb_reg;
        end
        else
        begin : g_nodiv
            assign hp[j+1] = FX_ONE - {1'b0, qa_reg};
            assign hy[j+1] = ya_reg;
            assign hz[j+1] = za_reg;
        end
    end

    assign sp[0] = hp[10];
    assign sz[0] = hz[10];

    // Five squarings raise the series value to the 32nd power.
    for (genvar s = 0; s < 5; s++)
    begin : g_square
        logic [63:0] sq;
        logic [31:0] p_reg;
        logic        z_reg;

        assign sq = 64'(sp[s]) * 64'(sp[s]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg <= sq[62:31];
                z_reg <= sz[s];
            end
        end

        assign sp[s+1] = p_reg;
        assign sz[s+1] = z_reg;
    end

    assign value = sz[5] ? 32'd0 : sp[5];

endmodule

>>> hdl/lcwe_mix.sv
module lcwe_mix (
    input  logic                         clk,
    input  logic                         en,
    input  logic [31:0]                  ea,
    input  logic [31:0]                  eb,
    input  logic [31:0]                  eg,
    input  logic [lcwe_pkg::AMP_W-1:0]   amp,
    output logic [lcwe_pkg::CUR_W-1:0]   current
);
    import lcwe_pkg::*;

    localparam logic [26:0] CUR_MAX = 27'((64'd1 << CUR_W) - 1);

    logic [31:0] d1_reg;
    logic [31:0] f1_reg;
    logic [31:0] d2_reg;
    logic [31:0] f2_reg;
    logic [31:0] w_reg;
    logic [CUR_W-1:0] cur_reg;

    logic [63:0] fsq;
    logic [63:0] dw;
    logic [49:0] aw;

    assign fsq = 64'(f1_reg) * 64'(f1_reg);
    assign dw  = 64'(d2_reg) * 64'(f2_reg);
    assign aw  = 50'(amp) * 50'(w_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A negative difference clamps to zero.
            d1_reg  <= (ea > eb) ? (ea - eb) : 32'd0;
            f1_reg  <= FX_ONE - eg;
            f2_reg  <= fsq[62:31];
            d2_reg  <= d1_reg;
            w_reg   <= dw[62:31];
            cur_reg <= (aw[49:23] > CUR_MAX) ? CUR_MAX[CUR_W-1:0] : aw[CUR_W+22:23];
        end
    end

    assign current = cur_reg;

endmodule

>>> hdl/lightning_current_waveform_eval_top.sv
// Each accepted input transaction passes through the exponential units, then the mix stage.
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds in place while a finished result waits at the output.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and loads
// the preset A waveform parameters into the configuration registers.
module lightning_current_waveform_eval_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lcwe_pkg::IDX_W-1:0]    cfg_index,
    input  logic [lcwe_pkg::RATE_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lcwe_pkg::TIME_W-1:0]   time_ns,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lcwe_pkg::CUR_W-1:0]    current
);
    import lcwe_pkg::*;

    logic [AMP_W-1:0]  peak_reg;
    logic [RATE_W-1:0] decay_reg;
    logic [RATE_W-1:0] rise_reg;
    logic [RATE_W-1:0] front_reg;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           en;

    logic [31:0] ea;
    logic [31:0] eb;
    logic [31:0] eg;

    // Configuration writes land directly; the user must make them only while idle, as the block has no check.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= PEAK_RST;
            decay_reg <= DECAY_RST;
            rise_reg  <= RISE_RST;
            front_reg <= FRONT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PEAK:  peak_reg  <= cfg_data[AMP_W-1:0];
                REG_DECAY: decay_reg <= cfg_data;
                REG_RISE:  rise_reg  <= cfg_data;
                REG_FRONT: front_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // The pipeline moves whenever the output stage is empty or being drained.
    // Bubbles travel as cleared valid bits beside the data.
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];

    // Three exponential units run in parallel on the same time sample.
    lcwe_exp u_exp_a (
        .clk     (clk),
        .en      (en),
        .rate    (decay_reg),
        .time_ns (time_ns),
        .value   (ea)
    );

    lcwe_exp u_exp_b (
        .clk     (clk),
        .en      (en),
        .rate    (rise_reg),
        .time_ns (time_ns),
        .value   (eb)
    );

    lcwe_exp u_exp_g (
        .clk     (clk),
        .en      (en),
        .rate    (front_reg),
        .time_ns (time_ns),
        .value   (eg)
    );

    // Difference, squared front factor, and amplitude scaling with saturation.
    lcwe_mix u_mix (
        .clk     (clk),
        .en      (en),
        .ea      (ea),
        .eb      (eb),
        .eg      (eg),
        .amp     (peak_reg),
        .current (current)
    );

    // An empty output stage never blocks new input.
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
        else $error("input blocked while output stage empty");

    // An accepted transaction enters the first valid stage.
    assert property (@(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted transaction lost at pipeline entry");

    // A stalled pipeline keeps all of its valid bits.
    assert property (@(posedge clk) disable iff (!rst_n) !en |=> $stable(vld_reg))
        else $error("valid bits changed during stall");

endmodule

>>> test/tb_lightning_current_waveform_eval_top.sv
module tb_lightning_current_waveform_eval_top;
    import lcwe_pkg::*;

    // Q1.31 one and the argument limit of the exponential, in Q.32.
    localparam longint unsigned ONE_Q31   = 64'h8000_0000;
    localparam longint unsigned ARG_LIMIT = 64'd24 << 32;
    localparam longint unsigned CUR_MAX   = 64'd67108863;

    // Scoreboard: a private copy of the waveform registers and the queue
    // of currents expected for the accepted time samples, oldest first.
    class current_scoreboard;
        logic [AMP_W-1:0]  peak;
        logic [RATE_W-1:0] decay;
        logic [RATE_W-1:0] rise;
        logic [RATE_W-1:0] front;
        logic [CUR_W-1:0]  expected_currents[$];

        function new();
            peak  = PEAK_RST;
            decay = DECAY_RST;
            rise  = RISE_RST;
            front = FRONT_RST;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [RATE_W-1:0] data);
            case (idx)
                REG_PEAK:  peak  = data[AMP_W-1:0];
                REG_DECAY: decay = data;
                REG_RISE:  rise  = data;
                REG_FRONT: front = data;
                default: ;
            endcase
        endfunction

        // exp(-x), x in Q.32, result in Q1.31. The argument is scaled by 1/32,
        // a tenth-order Taylor series is evaluated, and the result is squared
        // five times to undo the scaling.
        function longint unsigned exp_neg(longint unsigned x);
            longint unsigned y;
            longint unsigned p;
            if (x >= ARG_LIMIT)
                return 64'd0;
            y = x >> 6;
            p = ONE_Q31;
            for (int k = 10; k >= 1; k--)
                p = ONE_Q31 - ((y * p) >> 31) / longint'(k);
            for (int s = 0; s < 5; s++)
                p = (p * p) >> 31;
            return p;
        endfunction

        function logic [CUR_W-1:0] waveform_current(logic [TIME_W-1:0] t);
            longint unsigned ea, eb, eg, d, f, f2, w, cur;
            ea = exp_neg(longint'(decay) * longint'(t));
            eb = exp_neg(longint'(rise) * longint'(t));
            eg = exp_neg(longint'(front) * longint'(t));
            // A decay faster than the rise gives a negative difference,
            // which the block clamps to zero.
            d  = (ea > eb) ? ea - eb : 64'd0;
            f  = ONE_Q31 - eg;
            f2 = (f * f) >> 31;
            w  = (d * f2) >> 31;
            cur = (longint'(peak) * w) >> 23;
            if (cur > CUR_MAX)
                cur = CUR_MAX;
            return cur[CUR_W-1:0];
        endfunction

        function void note_sample(logic [TIME_W-1:0] t);
            expected_currents.push_back(waveform_current(t));
        endfunction

        // Returns 0 when nothing was waiting; exp holds the expectation.
        function bit check_current(logic [CUR_W-1:0] got, output logic [CUR_W-1:0] exp,
                                   output bit matched);
            matched = 0;
            exp = '0;
            if (expected_currents.size() == 0)
                return 0;
            exp = expected_currents.pop_front();
            matched = (exp == got);
            return 1;
        endfunction

        function int pending();
            return expected_currents.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [IDX_W-1:0]    cfg_index;
    logic [RATE_W-1:0]   cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [TIME_W-1:0]   time_ns;
    logic                out_valid;
    logic                out_ready;
    logic [CUR_W-1:0]    current;

    current_scoreboard sb;
    int  mismatches;
    // In the final stretch of the run neither side idles.
    bit  no_idle;

    lightning_current_waveform_eval_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .time_ns   (time_ns),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .current   (current)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hung pipeline must not leave the run open forever.
    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(string what, logic [CUR_W-1:0] exp, logic [CUR_W-1:0] got);
        $display("mismatch: %s expected %0d got %0d at %0t", what, exp, got, $realtime);
        mismatches++;
    endtask

    // Both handshakes are sampled at the rising edge, before any of this
    // edge's nonblocking updates land, so the values seen are the ones
    // the block itself acted on.
    always @(posedge clk)
    begin
        logic [CUR_W-1:0] exp;
        bit               matched;
        if (rst_n && in_valid && in_ready)
            sb.note_sample(time_ns);
        if (rst_n && out_valid && out_ready)
        begin
            if (!sb.check_current(current, exp, matched))
                report_mismatch("current transaction with none pending", '0, current);
            else if (!matched)
                report_mismatch("current", exp, current);
        end
    end

    // The result side stalls in random bursts.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!no_idle && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Writes one register. Must be called at a rising edge. The write
    // enable stays high so writes can follow back to back; the caller
    // lowers it after the last one.
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [RATE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Waits until every expected current has come out, plus a margin longer
    // than the pipeline depth so the block is surely idle.
    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    // Offers one time sample and holds it until the block takes it.
    // An idle burst, when taken, lowers valid first, so valid is never
    // lowered and raised in the same time step.
    task automatic send_time(logic [TIME_W-1:0] t);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        time_ns  <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Time just around the point where rate * t reaches 24, the edge at
    // which the exponential drops to zero.
    function automatic logic [TIME_W-1:0] knee_time(logic [RATE_W-1:0] rate, int offset);
        longint unsigned k;
        if (rate == 0)
            return $urandom;
        k = (ARG_LIMIT + rate - 1) / rate;
        k = k + longint'(offset);
        if (k > 64'hFFFF_FFFF)
            k = 64'hFFFF_FFFF;
        return k[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] random_time();
        logic [TIME_W-1:0] mask;
        int                off;
        off = $urandom_range(0, 6) - 3;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return knee_time(sb.decay, off);
            2: return knee_time(sb.rise, off);
            3: return knee_time(sb.front, off);
            default:
            begin
                // Mostly short times, where the waveform actually varies.
                mask = 32'hFFFF_FFFF >> $urandom_range(0, 31);
                return $urandom & mask;
            end
        endcase
    endfunction

    // One configuration phase: load the four registers while idle, then
    // stream random samples. Spare bits above the amplitude width are set
    // at random to show they are dropped.
    task automatic run_setting(logic [AMP_W-1:0] peak, logic [RATE_W-1:0] decay,
                               logic [RATE_W-1:0] rise, logic [RATE_W-1:0] front, int n);
        logic [RATE_W-1:0] pdata;
        wait_idle();
        pdata = RATE_W'($urandom) & ~((27'd1 << AMP_W) - 27'd1);
        pdata = pdata | RATE_W'(peak);
        write_reg(REG_PEAK, pdata);
        write_reg(REG_DECAY, decay);
        write_reg(REG_RISE, rise);
        write_reg(REG_FRONT, front);
        cfg_we <= 1'b0;
        for (int i = 0; i < n; i++)
            send_time(random_time());
        in_valid <= 1'b0;
    endtask

    initial
    begin
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        time_ns   <= '0;
        mismatches = 0;
        no_idle    = 0;
        sb = new();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples under the reset preset: time extremes, single
        // bits, and both sides of the large-argument edge of each rate.
        send_time(32'd0);
        send_time(32'd1);
        send_time(32'hFFFF_FFFF);
        send_time(32'h8000_0000);
        send_time(32'h5555_5555);
        send_time(32'hAAAA_AAAA);
        send_time(32'd100);
        send_time(32'd1000);
        send_time(32'd20000);
        send_time(32'd100000);
        for (int off = -1; off <= 1; off++)
        begin
            send_time(knee_time(sb.decay, off));
            send_time(knee_time(sb.rise, off));
            send_time(knee_time(sb.front, off));
        end
        in_valid <= 1'b0;

        // The reset preset, two loaded presets, and the extremes: all zero,
        // all maximum, a decay faster than the rise, which yields the clamped
        // negative difference, and the slowest decay against the fastest rise.
        run_setting(PEAK_RST, DECAY_RST, RISE_RST, FRONT_RST, 250);
        run_setting(18'd109405, 27'd97530, 27'd5559964, 27'd46587854, 250);
        run_setting(18'd10572, 27'd803983, 27'd82055690, 27'd77000000, 250);
        run_setting(18'd0, 27'd0, 27'd0, 27'd0, 100);
        run_setting(18'h3FFFF, 27'h7FF_FFFF, 27'h7FF_FFFF, 27'h7FF_FFFF, 150);
        run_setting(18'h3FFFF, 27'd5000000, 27'd40000, 27'd3000000, 200);
        run_setting(18'h3FFFF, 27'd1, 27'h7FF_FFFF, 27'h7FF_FFFF, 150);
        no_idle = 1;
        run_setting(18'd200000, 27'd30000, 27'd4000000, 27'd60000000, 150);

        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> lightning_current_waveform_eval_top.f
hdl/lcwe_pkg.sv
hdl/lcwe_exp.sv
hdl/lcwe_mix.sv
hdl/lightning_current_waveform_eval_top.sv
test/tb_lightning_current_waveform_eval_top.sv
